### rtl/pthc_pkg.sv
package pthc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int COEF_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SENS_BASE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMPCO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE    = 3'd5;

  localparam logic [1:0] HUM_STATUS_OK = 2'd2;

  localparam int TEMP_REF      = 2000;
  localparam int VLOW_BIAS     = 3500;   // TEMP + 1500 expressed from TEMP - 2000
  localparam int TEMP_VLOW_REL = -3500;  // TEMP < -1500 expressed from TEMP - 2000
  localparam int OFF2_A_K      = 61;
  localparam int SENS2_A_K     = 29;
  localparam int OFF2_B_K      = 17;
  localparam int SENS2_B_K     = 9;
  localparam int RH_SCALE      = 12500;
  localparam int RH_OFFSET     = 600;
  localparam int RH_TEMPCO     = 18;
  localparam int DIV100_MUL    = 10737419;  // ceil(2^30 / 100)
  localparam int DIV100_SH     = 30;
  localparam int P_MAX         = 4194303;
  localparam int RH_MIN        = -65536;
  localparam int RH_MAX        = 65535;
  localparam int T_MIN         = -262144;
  localparam int T_MAX         = 262143;

  typedef struct packed {
    logic [COEF_W-1:0] sens_base;
    logic [COEF_W-1:0] offset_base;
    logic [COEF_W-1:0] sens_tempco;
    logic [COEF_W-1:0] offset_tempco;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_slope;
  } coef_t;

  typedef struct packed {
    logic [23:0]        d1;
    logic signed [14:0] rh_base;
    logic               hval;
    logic signed [19:0] tfinal;
    logic [34:0]        a2;
    logic [34:0]        b2;
    logic               low;
    logic               vlow;
    logic signed [43:0] off_base;
    logic signed [43:0] sens_base;
  } front_bus_t;

endpackage

### rtl/pthc_if.sv
interface pthc_sample_if ();
  logic        valid;
  logic        ready;
  logic [23:0] raw_pressure;
  logic [23:0] raw_temperature;
  logic [15:0] raw_humidity_word;

  modport source (output valid, raw_pressure, raw_temperature, raw_humidity_word,
                  input ready);
  modport sink (input valid, raw_pressure, raw_temperature, raw_humidity_word,
                output ready);
endinterface

interface pthc_result_if ();
  logic               valid;
  logic               ready;
  logic signed [18:0] temperature_centi;
  logic [21:0]        pressure_pa;
  logic signed [16:0] humidity_centi;
  logic               humidity_valid;

  modport source (output valid, temperature_centi, pressure_pa, humidity_centi,
                  humidity_valid, input ready);
  modport sink (input valid, temperature_centi, pressure_pa, humidity_centi,
                humidity_valid, output ready);
endinterface

### rtl/pthc_front.sv
module pthc_front import pthc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  coef_t         coef,
  pthc_sample_if.sink   sample,
  output logic          bus_valid,
  input  logic          bus_ready,
  output front_bus_t    bus_data
);

  logic [4:1] v;
  logic [4:1] en;

  assign en[4] = !v[4] || bus_ready;
  assign en[3] = !v[3] || en[4];
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign sample.ready = en[1];
  assign bus_valid = v[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= sample.valid;
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
    end
  end

  // stage 1: dT, humidity base
  logic signed [24:0] dt_w;
  logic [13:0]        hraw_w;
  logic [27:0]        hprod_w;
  logic signed [14:0] rh_base_w;
  logic               hval_w;

  assign dt_w = $signed({1'b0, sample.raw_temperature})
              - $signed({1'b0, coef.ref_temp, 8'd0});
  assign hraw_w    = sample.raw_humidity_word[15:2];
  assign hprod_w   = 28'(hraw_w) * 28'(RH_SCALE);
  assign rh_base_w = $signed({1'b0, hprod_w[27:14]}) - 15'(RH_OFFSET);
  assign hval_w    = sample.raw_humidity_word[1:0] == HUM_STATUS_OK;

  logic signed [24:0] s1_dt;
  logic [23:0]        s1_d1;
  logic signed [14:0] s1_rh_base;
  logic               s1_hval;

  // stage 2: products with dT
  logic signed [16:0] c6_s, c4_s, c3_s;
  logic signed [41:0] dtc6_w, c4dt_w, c3dt_w;
  logic signed [49:0] dtsq_w;

  assign c6_s   = $signed({1'b0, coef.temp_slope});
  assign c4_s   = $signed({1'b0, coef.offset_tempco});
  assign c3_s   = $signed({1'b0, coef.sens_tempco});
  assign dtc6_w = s1_dt * c6_s;
  assign c4dt_w = s1_dt * c4_s;
  assign c3dt_w = s1_dt * c3_s;
  assign dtsq_w = s1_dt * s1_dt;

  logic signed [41:0] s2_dtc6, s2_c4dt, s2_c3dt;
  logic [47:0]        s2_dtsq;
  logic [23:0]        s2_d1;
  logic signed [14:0] s2_rh_base;
  logic               s2_hval;

  // stage 3: first-order TEMP, T2, base offset and sensitivity
  logic signed [18:0] a_w;
  logic               low_w, vlow_w;
  logic [49:0]        t2x3_w;
  logic [50:0]        t2x5_w;
  logic [16:0]        t2_w;
  logic signed [43:0] off_base_w, sens_base_w;
  logic signed [19:0] b_w;

  assign a_w    = s2_dtc6[41:23];
  assign low_w  = a_w[18];
  assign vlow_w = a_w < 19'(TEMP_VLOW_REL);
  assign t2x3_w = {1'b0, s2_dtsq, 1'b0} + {2'b0, s2_dtsq};
  assign t2x5_w = {1'b0, s2_dtsq, 2'b0} + {3'b0, s2_dtsq};
  assign t2_w   = low_w ? t2x3_w[49:33] : {4'd0, t2x5_w[50:38]};
  assign off_base_w  = {11'd0, coef.offset_base, 17'd0}
                     + {{8{s2_c4dt[41]}}, s2_c4dt[41:6]};
  assign sens_base_w = {12'd0, coef.sens_base, 16'd0}
                     + {{9{s2_c3dt[41]}}, s2_c3dt[41:7]};
  assign b_w = {a_w[18], a_w} + 20'(VLOW_BIAS);

  logic signed [18:0] s3_a;
  logic signed [19:0] s3_b;
  logic               s3_low, s3_vlow;
  logic [16:0]        s3_t2;
  logic signed [43:0] s3_off_base, s3_sens_base;
  logic [23:0]        s3_d1;
  logic signed [14:0] s3_rh_base;
  logic               s3_hval;

  // stage 4: squares, final temperature
  logic signed [37:0] a2_w;
  logic signed [39:0] b2_w;
  logic signed [19:0] tfinal_w;

  assign a2_w     = s3_a * s3_a;
  assign b2_w     = s3_b * s3_b;
  assign tfinal_w = {s3_a[18], s3_a} + 20'(TEMP_REF) - {3'd0, s3_t2};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_dt      <= dt_w;
      s1_d1      <= sample.raw_pressure;
      s1_rh_base <= rh_base_w;
      s1_hval    <= hval_w;
    end
    if (en[2]) begin
      s2_dtc6    <= dtc6_w;
      s2_c4dt    <= c4dt_w;
      s2_c3dt    <= c3dt_w;
      s2_dtsq    <= dtsq_w[47:0];
      s2_d1      <= s1_d1;
      s2_rh_base <= s1_rh_base;
      s2_hval    <= s1_hval;
    end
    if (en[3]) begin
      s3_a         <= a_w;
      s3_b         <= b_w;
      s3_low       <= low_w;
      s3_vlow      <= vlow_w;
      s3_t2        <= t2_w;
      s3_off_base  <= off_base_w;
      s3_sens_base <= sens_base_w;
      s3_d1        <= s2_d1;
      s3_rh_base   <= s2_rh_base;
      s3_hval      <= s2_hval;
    end
    if (en[4]) begin
      bus_data.d1        <= s3_d1;
      bus_data.rh_base   <= s3_rh_base;
      bus_data.hval      <= s3_hval;
      bus_data.tfinal    <= tfinal_w;
      bus_data.a2        <= a2_w[34:0];
      bus_data.b2        <= b2_w[34:0];
      bus_data.low       <= s3_low;
      bus_data.vlow      <= s3_vlow;
      bus_data.off_base  <= s3_off_base;
      bus_data.sens_base <= s3_sens_base;
    end
  end

endmodule

### rtl/pthc_back.sv
module pthc_back import pthc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          bus_valid,
  output logic          bus_ready,
  input  front_bus_t    bus_data,
  pthc_result_if.source result
);

  logic [8:5] v;
  logic [8:5] en;

  assign en[8] = !v[8] || result.ready;
  assign en[7] = !v[7] || en[8];
  assign en[6] = !v[6] || en[7];
  assign en[5] = !v[5] || en[6];
  assign bus_ready = en[5];
  assign result.valid = v[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[5]) v[5] <= bus_valid;
      if (en[6]) v[6] <= v[5];
      if (en[7]) v[7] <= v[6];
      if (en[8]) v[8] <= v[7];
    end
  end

  // stage 5: OFF2, SENS2, humidity temperature term
  logic [40:0]        offa_w;
  logic [38:0]        offb_w;
  logic [39:0]        sensa_w;
  logic [37:0]        sensb_w;
  logic [39:0]        off2_w, sens2_w;
  logic signed [20:0] tm_w;
  logic signed [25:0] x_w;
  logic [25:0]        xabs_w;

  assign offa_w  = 41'(bus_data.a2) * 41'(OFF2_A_K);
  assign offb_w  = 39'(bus_data.b2) * 39'(OFF2_B_K);
  assign sensa_w = 40'(bus_data.a2) * 40'(SENS2_A_K);
  assign sensb_w = 38'(bus_data.b2) * 38'(SENS2_B_K);
  assign off2_w  = !bus_data.low ? 40'd0 :
                   40'(offa_w[40:4]) + (bus_data.vlow ? 40'(offb_w) : 40'd0);
  assign sens2_w = !bus_data.low ? 40'd0 :
                   40'(sensa_w[39:4]) + (bus_data.vlow ? 40'(sensb_w) : 40'd0);
  assign tm_w   = {bus_data.tfinal[19], bus_data.tfinal} - 21'(TEMP_REF);
  assign x_w    = tm_w * 26'(RH_TEMPCO);
  assign xabs_w = x_w[25] ? 26'(-x_w) : 26'(x_w);

  logic [39:0]        s5_off2, s5_sens2;
  logic signed [43:0] s5_off_base, s5_sens_base;
  logic [22:0]        s5_xmag;
  logic               s5_xneg;
  logic [23:0]        s5_d1;
  logic signed [14:0] s5_rh_base;
  logic               s5_hval;
  logic signed [19:0] s5_tfinal;

  // stage 6: OFF, SENS, reciprocal product for the division by 100
  logic signed [43:0] off_w, sens_w;
  logic [46:0]        prod_w;

  assign off_w  = s5_off_base - $signed({4'd0, s5_off2});
  assign sens_w = s5_sens_base - $signed({4'd0, s5_sens2});
  assign prod_w = 47'(s5_xmag) * 47'(DIV100_MUL);

  logic signed [43:0] s6_off, s6_sens;
  logic [46:0]        s6_prod;
  logic               s6_xneg;
  logic [23:0]        s6_d1;
  logic signed [14:0] s6_rh_base;
  logic               s6_hval;
  logic signed [19:0] s6_tfinal;

  // stage 7: D1 * SENS in two halves, humidity sum
  logic signed [22:0] hi_w;
  logic [20:0]        lo_w;
  logic signed [24:0] d1s_w;
  logic signed [47:0] d1hi_w;
  logic [44:0]        d1lo_w;
  logic [16:0]        q_w;
  logic signed [18:0] rh_w;

  assign hi_w   = s6_sens[43:21];
  assign lo_w   = s6_sens[20:0];
  assign d1s_w  = $signed({1'b0, s6_d1});
  assign d1hi_w = d1s_w * hi_w;
  assign d1lo_w = 45'(s6_d1) * 45'(lo_w);
  assign q_w    = s6_prod[46:DIV100_SH];
  assign rh_w   = {{4{s6_rh_base[14]}}, s6_rh_base}
                + (s6_xneg ? 19'(-{2'b0, q_w}) : {2'b0, q_w});

  logic signed [47:0] s7_d1hi;
  logic [44:0]        s7_d1lo;
  logic signed [43:0] s7_off;
  logic signed [18:0] s7_rh;
  logic               s7_hval;
  logic signed [19:0] s7_tfinal;

  // stage 8: pressure, clamps
  logic signed [49:0] sum_w;
  logic signed [34:0] p_w;
  logic [21:0]        p_sat_w;
  logic signed [16:0] rh_sat_w;
  logic signed [18:0] t_sat_w;

  assign sum_w = {{2{s7_d1hi[47]}}, s7_d1hi} + {26'd0, s7_d1lo[44:21]}
               - {{6{s7_off[43]}}, s7_off};
  assign p_w   = sum_w[49:15];

  always_comb begin
    if (p_w[34]) begin
      p_sat_w = '0;
    end else if (|p_w[33:22]) begin
      p_sat_w = 22'(P_MAX);
    end else begin
      p_sat_w = p_w[21:0];
    end
    if (!s7_hval) begin
      rh_sat_w = '0;
    end else if (s7_rh < 19'(RH_MIN)) begin
      rh_sat_w = 17'(RH_MIN);
    end else if (s7_rh > 19'(RH_MAX)) begin
      rh_sat_w = 17'(RH_MAX);
    end else begin
      rh_sat_w = s7_rh[16:0];
    end
    if (s7_tfinal < 20'(T_MIN)) begin
      t_sat_w = 19'(T_MIN);
    end else if (s7_tfinal > 20'(T_MAX)) begin
      t_sat_w = 19'(T_MAX);
    end else begin
      t_sat_w = s7_tfinal[18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_off2      <= off2_w;
      s5_sens2     <= sens2_w;
      s5_off_base  <= bus_data.off_base;
      s5_sens_base <= bus_data.sens_base;
      s5_xmag      <= xabs_w[22:0];
      s5_xneg      <= x_w[25];
      s5_d1        <= bus_data.d1;
      s5_rh_base   <= bus_data.rh_base;
      s5_hval      <= bus_data.hval;
      s5_tfinal    <= bus_data.tfinal;
    end
    if (en[6]) begin
      s6_off     <= off_w;
      s6_sens    <= sens_w;
      s6_prod    <= prod_w;
      s6_xneg    <= s5_xneg;
      s6_d1      <= s5_d1;
      s6_rh_base <= s5_rh_base;
      s6_hval    <= s5_hval;
      s6_tfinal  <= s5_tfinal;
    end
    if (en[7]) begin
      s7_d1hi   <= d1hi_w;
      s7_d1lo   <= d1lo_w;
      s7_off    <= s6_off;
      s7_rh     <= rh_w;
      s7_hval   <= s6_hval;
      s7_tfinal <= s6_tfinal;
    end
    if (en[8]) begin
      result.temperature_centi <= t_sat_w;
      result.pressure_pa       <= p_sat_w;
      result.humidity_centi    <= rh_sat_w;
      result.humidity_valid    <= s7_hval;
    end
  end

endmodule

### rtl/pth_sensor_compensation.sv
// Second-order compensation for a pressure/temperature/humidity sensor. Each
// sample beat (raw D1, D2 and humidity word) yields one result beat with
// temperature in 0.01 degC, pressure in Pa and humidity in 0.01 %RH, plus a
// humidity valid flag from the status bits. The datapath is an eight-stage
// multiplier pipeline that sustains one beat per cycle while the output is
// not stalled. Each stage holds its beat only while the stage after it is
// full and stalled, so bubbles close up and the block keeps taking samples
// while a result waits. The six calibration words reset to zero and may be
// written only while no sample is in flight; writes to indexes past the last
// word are dropped.
module pth_sensor_compensation import pthc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  pthc_sample_if.sink          sample,
  pthc_result_if.source        result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  coef_t      coef;
  logic       bus_valid;
  logic       bus_ready;
  front_bus_t bus_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SENS_BASE:     coef.sens_base     <= cfg_data;
        REG_OFFSET_BASE:   coef.offset_base   <= cfg_data;
        REG_SENS_TEMPCO:   coef.sens_tempco   <= cfg_data;
        REG_OFFSET_TEMPCO: coef.offset_tempco <= cfg_data;
        REG_REF_TEMP:      coef.ref_temp      <= cfg_data;
        REG_TEMP_SLOPE:    coef.temp_slope    <= cfg_data;
        default: ;
      endcase
    end
  end

  pthc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .sample    (sample),
    .bus_valid (bus_valid),
    .bus_ready (bus_ready),
    .bus_data  (bus_data)
  );

  pthc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .bus_valid (bus_valid),
    .bus_ready (bus_ready),
    .bus_data  (bus_data),
    .result    (result)
  );

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("sample not ready with result stage empty");

  a_hum_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.humidity_valid |-> result.humidity_centi == '0)
    else $error("humidity value nonzero without valid status");

  a_link_hold: assert property (@(posedge clk) disable iff (rst)
    bus_valid && !bus_ready |=> bus_valid && $stable(bus_data))
    else $error("front-to-back beat lost during stall");

endmodule
